/* src/dse_pkg.sv */
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and constants for the scaled decimal equality unit.
// ----------------------------------------------------------------------------
package dse_pkg;

    // Mantissa and scale geometry.
    localparam int MANTISSA_BITS = 96;
    localparam int WORD_BITS     = 32;
    localparam int SCALE_BITS    = 5;
    localparam logic [SCALE_BITS-1:0] MAX_SCALE = SCALE_BITS'(28);

    typedef logic [MANTISSA_BITS-1:0] mant_t;
    typedef logic [WORD_BITS-1:0]     word_t;
    typedef logic [SCALE_BITS-1:0]    scale_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new operand pair
        logic step;    // one multiply-by-ten step on the lower-scale mantissa
        logic finish;  // evaluate the comparison into the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic align_done;  // no steps left, or the alignment overflowed
    } dp_stat_t;

    // Saturate a scale to the largest supported exponent.
    function automatic scale_t clamp_scale(input scale_t s);
        return (s > MAX_SCALE) ? MAX_SCALE : s;
    endfunction

endpackage

/* src/dse_datapath.sv */
// ----------------------------------------------------------------------------
// dse_datapath
// Operand registers, the shared multiply-by-ten unit, the step counter and
// the final comparison.
// ----------------------------------------------------------------------------
module dse_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  dse_pkg::dp_cmd_t   cmd,
    output dse_pkg::dp_stat_t  stat,
    input  dse_pkg::word_t     a_word0,
    input  dse_pkg::word_t     a_word1,
    input  dse_pkg::word_t     a_word2,
    input  dse_pkg::scale_t    a_scale,
    input  logic               a_negative,
    input  dse_pkg::word_t     b_word0,
    input  dse_pkg::word_t     b_word1,
    input  dse_pkg::word_t     b_word2,
    input  dse_pkg::scale_t    b_scale,
    input  logic               b_negative,
    output logic               are_equal
);
    import dse_pkg::*;

    mant_t  ma_reg, ma_next;
    mant_t  mb_reg, mb_next;
    logic   na_reg, nb_reg;
    scale_t count_reg, count_next;
    logic   sel_b_reg;            // high when operand b is the one scaled up
    logic   over_reg, over_next;
    logic   result_reg;

    scale_t sa, sb;
    mant_t  src;
    logic [MANTISSA_BITS+3:0] prod;
    logic   eq;

    assign sa = clamp_scale(a_scale);
    assign sb = clamp_scale(b_scale);

    // Multiply by ten as (x << 3) + (x << 1); the top four bits flag overflow.
    assign src  = sel_b_reg ? mb_reg : ma_reg;
    assign prod = {1'b0, src, 3'b000} + {3'b000, src, 1'b0};

    // Next values of the operand registers and the step counter.
    always_comb begin
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        count_next = count_reg;
        over_next  = over_reg;
        if (cmd.load) begin
            ma_next    = {a_word2, a_word1, a_word0};
            mb_next    = {b_word2, b_word1, b_word0};
            count_next = (sa > sb) ? (sa - sb) : (sb - sa);
            over_next  = 1'b0;
        end else if (cmd.step) begin
            if (sel_b_reg) begin
                mb_next = prod[MANTISSA_BITS-1:0];
            end else begin
                ma_next = prod[MANTISSA_BITS-1:0];
            end
            count_next = count_reg - scale_t'(1);
            over_next  = |prod[MANTISSA_BITS+3:MANTISSA_BITS];
        end
    end

    // Equality of the aligned values; two zeros match whatever the signs.
    assign eq = !over_reg &&
                (((ma_reg == mb_reg) && (na_reg == nb_reg)) ||
                 ((ma_reg == '0) && (mb_reg == '0)));

    // Payload registers.
    always_ff @(posedge aclk) begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        if (cmd.load) begin
            na_reg    <= a_negative;
            nb_reg    <= b_negative;
            sel_b_reg <= (sa > sb);
        end
        if (cmd.finish) begin
            result_reg <= eq;
        end
    end

    // Step control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            over_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            over_reg  <= over_next;
        end
    end

    assign stat.align_done = (count_reg == '0) || over_reg;
    assign are_equal       = result_reg;

endmodule

/* src/dse_controller.sv */
// ----------------------------------------------------------------------------
// dse_controller
// State machine that sequences load, alignment steps, comparison and the
// result transfer.
// ----------------------------------------------------------------------------
module dse_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output dse_pkg::dp_cmd_t   cmd,
    input  dse_pkg::dp_stat_t  stat
);
    import dse_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ALIGN = 3'b010,
        ST_OUT   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (stat.align_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

endmodule

/* src/decimal96_scaled_equality_unit.sv */
// ----------------------------------------------------------------------------
// decimal96_scaled_equality_unit
// Equality test for two scaled 96-bit decimal numbers.
// ----------------------------------------------------------------------------
// The result is offered once d alignment steps are done, where d is the
// difference of the two scales after they are saturated to 28, or fewer
// when alignment overflows early, and it is held until m_ready takes it.
// The single multiply-by-ten unit scales the lower-scale mantissa up by one
// decade per cycle; alignment stops at the first product that overflows
// 96 bits, which reports not equal. Two zero mantissas are equal regardless
// of sign and scale. A new operand pair is taken once the previous result
// has been transferred.
module decimal96_scaled_equality_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dse_pkg::word_t   s_a_word0,
    input  dse_pkg::word_t   s_a_word1,
    input  dse_pkg::word_t   s_a_word2,
    input  dse_pkg::scale_t  s_a_scale,
    input  logic             s_a_negative,
    input  dse_pkg::word_t   s_b_word0,
    input  dse_pkg::word_t   s_b_word1,
    input  dse_pkg::word_t   s_b_word2,
    input  dse_pkg::scale_t  s_b_scale,
    input  logic             s_b_negative,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_are_equal
);
    import dse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing of each comparison.
    dse_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Operand storage, alignment and comparison.
    dse_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .a_word0    (s_a_word0),
        .a_word1    (s_a_word1),
        .a_word2    (s_a_word2),
        .a_scale    (s_a_scale),
        .a_negative (s_a_negative),
        .b_word0    (s_b_word0),
        .b_word1    (s_b_word1),
        .b_word2    (s_b_word2),
        .b_scale    (s_b_scale),
        .b_negative (s_b_negative),
        .are_equal  (m_are_equal)
    );

endmodule

/* test/dse_check_pkg.sv */
// ----------------------------------------------------------------------------
// dse_check_pkg
// Operand type and result scoreboard for the scaled decimal equality checks.
// The scoreboard predicts are_equal for every operand pair that the unit
// accepts, queues the prediction and compares it with each result transfer.
// ----------------------------------------------------------------------------
package dse_check_pkg;

    import dse_pkg::*;

    // One decimal operand: mantissa, scale code and sign.
    typedef struct packed {
        mant_t  mant;
        scale_t scale;
        logic   negative;
    } decimal_t;

    // Mantissa plus four guard bits, enough for one multiply by ten.
    localparam int PRODUCT_BITS = MANTISSA_BITS + 4;

    function automatic mant_t power_of_ten(input int n);
        mant_t p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    class equality_scoreboard;

        bit expected_q[$];
        int mismatches = 0;
        int compared   = 0;
        int equal_seen = 0;

        // Codes above the largest supported scale behave as the largest scale.
        function int effective_scale(scale_t s);
            return (s > MAX_SCALE) ? int'(MAX_SCALE) : int'(s);
        endfunction

        // Scale a mantissa up by one decade; returns 1 when the product is too wide.
        function bit times_ten(inout mant_t m);
            logic [PRODUCT_BITS-1:0] p;
            p = PRODUCT_BITS'(m) * 10;
            m = p[MANTISSA_BITS-1:0];
            return |p[PRODUCT_BITS-1:MANTISSA_BITS];
        endfunction

        // Align the lower-scale mantissa step by step, stopping at the first overflow.
        function bit predict_equal(decimal_t a, decimal_t b);
            mant_t ma       = a.mant;
            mant_t mb       = b.mant;
            int    sa       = effective_scale(a.scale);
            int    sb       = effective_scale(b.scale);
            bit    overflow = 1'b0;
            for (int k = 0; k < sa - sb && !overflow; k++) begin
                overflow = times_ten(mb);
            end
            for (int k = 0; k < sb - sa && !overflow; k++) begin
                overflow = times_ten(ma);
            end
            return !overflow && ((ma == mb && a.negative == b.negative) ||
                                 (ma == '0 && mb == '0));
        endfunction

        // Called on every input transfer.
        function void note_operands(decimal_t a, decimal_t b);
            expected_q.push_back(predict_equal(a, b));
        endfunction

        // Called on every result transfer.
        function void check_result(logic got);
            bit want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $error("are_equal: result with no comparison pending, actual %0b", got);
                return;
            end
            want = expected_q.pop_front();
            compared++;
            if (got === 1'b1) begin
                equal_seen++;
            end
            if (got !== want) begin
                mismatches++;
                $error("are_equal mismatch: expected %0b, actual %0b", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for decimal96_scaled_equality_unit.
// Drives operand pairs over the input channel and checks every result
// against a scoreboard prediction: a directed set of edge cases (zeros,
// saturated scales, full-width mantissas, overflow at the alignment limit)
// followed by random pairs biased toward equal values, near misses and
// overflow boundaries, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dse_pkg::*;
    import dse_check_pkg::*;

    localparam int RANDOM_PAIRS = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;

    logic   aclk = 1'b0;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    word_t  s_a_word0, s_a_word1, s_a_word2;
    scale_t s_a_scale;
    logic   s_a_negative;
    word_t  s_b_word0, s_b_word1, s_b_word2;
    scale_t s_b_scale;
    logic   s_b_negative;
    logic   m_valid;
    logic   m_ready;
    logic   m_are_equal;

    equality_scoreboard sb = new();

    int sent_pairs    = 0;
    int cycle_count   = 0;
    bit steady_stream = 1'b0;

    decimal96_scaled_equality_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_a_word0    (s_a_word0),
        .s_a_word1    (s_a_word1),
        .s_a_word2    (s_a_word2),
        .s_a_scale    (s_a_scale),
        .s_a_negative (s_a_negative),
        .s_b_word0    (s_b_word0),
        .s_b_word1    (s_b_word1),
        .s_b_word2    (s_b_word2),
        .s_b_scale    (s_b_scale),
        .s_b_negative (s_b_negative),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_are_equal  (m_are_equal)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic decimal_t mk(input mant_t m, input int s, input logic n);
        decimal_t v;
        v.mant     = m;
        v.scale    = scale_t'(s);
        v.negative = n;
        return v;
    endfunction

    function automatic mant_t random_mantissa();
        return {$urandom, $urandom, $urandom};
    endfunction

    // Scale 28 is sometimes coded as one of the saturating codes above it.
    function automatic scale_t scale_code(input int s);
        return (s == 28) ? scale_t'($urandom_range(28, 31)) : scale_t'(s);
    endfunction

    // Offer one operand pair after a random gap and hold it until the transfer.
    task automatic drive_pair(input decimal_t a, input decimal_t b);
        int gap;
        gap = steady_stream ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_a_word0    <= a.mant[31:0];
        s_a_word1    <= a.mant[63:32];
        s_a_word2    <= a.mant[95:64];
        s_a_scale    <= a.scale;
        s_a_negative <= a.negative;
        s_b_word0    <= b.mant[31:0];
        s_b_word1    <= b.mant[63:32];
        s_b_word2    <= b.mant[95:64];
        s_b_scale    <= b.scale;
        s_b_negative <= b.negative;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_operands(a, b);
        sent_pairs++;
    endtask

    // Accept results with random stalls and hand each one to the scoreboard.
    task automatic take_results();
        int stall;
        forever begin
            stall = steady_stream ? 0 : $urandom_range(0, 5);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_result(m_are_equal);
        end
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Build a random pair. Most pairs are structured so that the alignment
    // path matters: equal values at different scales, near misses, and
    // mantissas right at the overflow limit.
    task automatic make_random_pair(output decimal_t a, output decimal_t b);
        int       kind, d, lo, hi, shift;
        logic     neg;
        mant_t    m, big, limit;
        logic [127:0] wide;
        decimal_t x, y;
        kind = $urandom_range(0, 99);
        d    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 28) : $urandom_range(0, 6);
        if (kind >= 55 && kind < 70 && d == 0) begin
            d = 1;
        end
        lo  = $urandom_range(0, 28 - d);
        hi  = lo + d;
        neg = $urandom_range(0, 1);
        if (kind < 55) begin
            // Equal values, or one bit or one unit off.
            shift = (d * 10 + 2) / 3 + 1 + $urandom_range(0, 60);
            if (shift > 95) begin
                shift = 95;
            end
            m   = random_mantissa() >> shift;
            big = m * power_of_ten(d);
            if (kind >= 40) begin
                if ($urandom_range(0, 1) == 1) begin
                    big = big + 1;
                end else begin
                    big[$urandom_range(0, 95)] ^= 1'b1;
                end
            end
            x = mk(m, 0, neg);
            y = mk(big, 0, neg);
            x.scale = scale_code(lo);
            y.scale = scale_code(hi);
            if ($urandom_range(0, 9) == 0) begin
                y.negative = !neg;
            end
        end else if (kind < 70) begin
            // Around the largest mantissa that still survives alignment.
            limit = ~mant_t'(0) / power_of_ten(d);
            m     = limit + mant_t'($urandom_range(0, 3)) - 1;
            wide  = 128'(m) * 128'(power_of_ten(d));
            x = mk(m, 0, neg);
            y = mk(wide[95:0], 0, neg);
            x.scale = scale_code(lo);
            y.scale = scale_code(hi);
        end else if (kind < 80) begin
            // Zeros with any sign and scale code, sometimes against a nonzero mantissa.
            x = mk('0, $urandom_range(0, 31), $urandom_range(0, 1));
            y = mk('0, $urandom_range(0, 31), $urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) begin
                y.mant = random_mantissa() >> $urandom_range(0, 95);
            end
        end else begin
            // Unconstrained operands.
            x = mk(random_mantissa(), $urandom_range(0, 31), $urandom_range(0, 1));
            y = mk(random_mantissa(), $urandom_range(0, 31), $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
                x.mant = x.mant >> $urandom_range(0, 95);
            end
            if ($urandom_range(0, 9) == 0) begin
                y.mant = x.mant;
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            a = x;
            b = y;
        end else begin
            a = y;
            b = x;
        end
    endtask

    initial begin
        mant_t    full_scale;
        mant_t    survivor;
        int       directed_pairs;
        decimal_t a, b;

        full_scale = '1;
        survivor   = full_scale / 10;

        // Every input known from time zero.
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_a_word0    = '0;
        s_a_word1    = '0;
        s_a_word2    = '0;
        s_a_scale    = '0;
        s_a_negative = 1'b0;
        s_b_word0    = '0;
        s_b_word1    = '0;
        s_b_word2    = '0;
        s_b_scale    = '0;
        s_b_negative = 1'b0;
        m_ready      = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        fork
            take_results();
        join_none

        // Directed cases: zeros, full-width mantissas, signs, saturated
        // scales, longest alignment and overflow on both sides of the limit.
        drive_pair(mk('0, 0, 1'b0), mk('0, 0, 1'b0));
        drive_pair(mk('0, 0, 1'b1), mk('0, 28, 1'b0));
        drive_pair(mk('0, 31, 1'b1), mk('0, 0, 1'b1));
        drive_pair(mk(full_scale, 28, 1'b0), mk(full_scale, 28, 1'b0));
        drive_pair(mk(full_scale, 0, 1'b1), mk(full_scale, 0, 1'b0));
        drive_pair(mk(1, 0, 1'b0), mk(10, 1, 1'b0));
        drive_pair(mk(10, 1, 1'b1), mk(1, 0, 1'b1));
        drive_pair(mk(1, 0, 1'b0), mk(power_of_ten(28), 28, 1'b0));
        drive_pair(mk(power_of_ten(28), 31, 1'b1), mk(1, 0, 1'b1));
        drive_pair(mk(5, 29, 1'b0), mk(5, 30, 1'b0));
        drive_pair(mk(5, 28, 1'b0), mk(5, 27, 1'b0));
        drive_pair(mk(full_scale, 0, 1'b0), mk(full_scale, 1, 1'b0));
        drive_pair(mk(survivor, 0, 1'b0), mk(survivor * 10, 1, 1'b0));
        drive_pair(mk(survivor * 10, 1, 1'b1), mk(survivor, 0, 1'b1));
        drive_pair(mk(survivor + 1, 0, 1'b0), mk((survivor + 1) * 10, 1, 1'b0));
        drive_pair(mk('0, 0, 1'b0), mk(1, 28, 1'b0));
        drive_pair(mk(1, 0, 1'b0), mk('0, 28, 1'b0));
        drive_pair(mk(full_scale, 0, 1'b0), mk('0, 28, 1'b0));
        drive_pair(mk('0, 0, 1'b0), mk(full_scale, 28, 1'b1));
        drive_pair(mk(96'h00000000_FFFFFFFF_00000000, 3, 1'b0),
                   mk(96'h00000000_FFFFFFFF_00000000, 3, 1'b0));
        drive_pair(mk(96'hAAAAAAAA_55555555_AAAAAAAA, 5, 1'b1),
                   mk(96'h55555555_AAAAAAAA_55555555, 5, 1'b1));
        drive_pair(mk(96'hFFFFFFFF_00000000_FFFFFFFF, 31, 1'b1),
                   mk(96'hFFFFFFFF_00000000_FFFFFFFF, 28, 1'b1));
        directed_pairs = sent_pairs;

        // Hold the sender until the pipeline is empty.
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_results();

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            steady_stream = (i % 400) >= 340;
            if (i % 300 == 150) begin
                // Drop valid so the last pair is not offered again while draining.
                @(negedge aclk);
                s_valid <= 1'b0;
                wait_for_results();
            end
            make_random_pair(a, b);
            drive_pair(a, b);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d operand pairs (%0d directed, %0d random), scale codes 0..31.",
                 sent_pairs, directed_pairs, sent_pairs - directed_pairs);
        $display("Checked %0d results: %0d equal, %0d not equal.",
                 sb.compared, sb.equal_seen, sb.compared - sb.equal_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
